@@ src/case_folded_multi_pattern_scanner_assert.svh @@
// assertion macros used by the scanner checker
`ifndef CASE_FOLDED_MULTI_PATTERN_SCANNER_ASSERT_SVH
`define CASE_FOLDED_MULTI_PATTERN_SCANNER_ASSERT_SVH

// same-cycle implication, reset masks the check
`define CFMPS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, reset masks the check
`define CFMPS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/cfmps_pkg.sv @@
// shared types, codes and helpers of the case-folded pattern scanner
package cfmps_pkg;

   // input actions carried in tuser
   localparam logic [1:0] ACTION_HDR  = 2'd0;
   localparam logic [1:0] ACTION_PAT  = 2'd1;
   localparam logic [1:0] ACTION_TEXT = 2'd2;
   localparam logic [1:0] ACTION_END  = 2'd3;

   // configuration register indexes
   localparam logic [0:0] CSR_FLOOR      = 1'd0;
   localparam logic [0:0] CSR_RULE_COUNT = 1'd1;

   // verdict codes
   localparam logic [1:0] VERDICT_ALLOW    = 2'd0;
   localparam logic [1:0] VERDICT_REFUSE   = 2'd1;
   localparam logic [1:0] VERDICT_FAILSAFE = 2'd2;

   // port widths
   localparam int REQ_TDATA_W = 48;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_DATA_W  = 6;

   // ascii folding constants
   localparam logic [7:0] UPPER_FIRST = 8'h41;
   localparam logic [7:0] UPPER_LAST  = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'd32;

   // payload fields of one request transfer
   typedef struct packed {
      logic [15:0] rule_class;
      logic [6:0]  pattern_length;
      logic [7:0]  data_byte;
      logic [5:0]  byte_pos;
      logic [4:0]  rule_index;
   } req_item_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH_FIRST,
      ST_LOOKUP_FIRST,
      ST_COMMIT_FIRST,
      ST_SCAN,
      ST_DRAIN,
      ST_SEARCH_END,
      ST_LOOKUP_END,
      ST_RESULT
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic accept;
      logic ptr_clear;
      logic ptr_step;
      logic scan_issue;
      logic class_capture;
      logic class_zero;
      logic first_commit;
      logic result_load;
      logic query_clear;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic active_zero;
      logic ptr_last;
      logic hit_at_ptr;
      logic pipe_busy;
      logic item_last;
      logic in_second;
      logic out_free;
   } dp_status_type;

   // fold ascii upper case to lower case
   function automatic logic [7:0] fold_byte(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= UPPER_FIRST && c <= UPPER_LAST) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

@@ src/cfmps_ram.sv @@
// generic single-write, single-read ram with registered read data
module cfmps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/cfmps_datapath.sv @@
// scanner datapath: rule tables, text window, match pipeline, result register
module cfmps_datapath #(
   parameter int RULE_SLOTS    = 32,
   parameter int PATTERN_BYTES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cfmps_pkg::ctrl_cmd_type           cmd,
   output cfmps_pkg::dp_status_type          status,
   input  logic [1:0]                        req_action,
   input  cfmps_pkg::req_item_type           req_item,
   input  logic                              req_second,
   input  logic                              req_last,
   input  logic                              csr_wr_en,
   input  logic [0:0]                        csr_index,
   input  logic [cfmps_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_verdict,
   output logic [15:0]                       rsp_class
);

   localparam int RIW   = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
   localparam int AW    = $clog2(RULE_SLOTS + 1);
   localparam int BSW   = $clog2(PATTERN_BYTES + 1);
   localparam int SHW   = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
   localparam int ROW_W = 8 * PATTERN_BYTES;
   localparam int HDR_W = 23;

   // configuration registers
   logic       floor_ff, floor_in;
   logic [5:0] rule_count_ff, rule_count_in;

   // rule pointer shared by scan and search
   logic [RIW-1:0] ptr_ff, ptr_in;
   logic [6:0]     rc_ext;
   logic [AW-1:0]  active;

   // header table
   logic                  hdr_wr_en;
   logic [HDR_W-1:0]      hdr_q;
   logic [RULE_SLOTS-1:0] hdr_valid_ff;
   logic                  hdr_vld_q_ff;
   logic [RIW-1:0]        wr_idx;

   // pattern lanes, one ram per pattern position
   logic [PATTERN_BYTES-1:0] lane_we;
   logic [7:0]               lane_q [PATTERN_BYTES];
   logic [7:0]               pat_folded;

   // query state
   logic [7:0]            window_ff [PATTERN_BYTES];
   logic [BSW-1:0]        bytes_seen_ff, bytes_seen_in;
   logic [RULE_SLOTS-1:0] hit_flags_ff;
   logic [15:0]           cur_class_ff, cur_class_in;
   logic [15:0]           first_class_ff, first_class_in;
   logic                  in_second_ff, in_second_in;
   logic                  item_last_ff, item_last_in;
   logic                  take_text;
   logic                  switch_text;

   // match pipeline
   logic                     s1_vld_ff;
   logic [RIW-1:0]           s1_idx_ff;
   logic [6:0]               s1_len;
   logic [SHW-1:0]           shamt;
   logic [ROW_W-1:0]         rev_row;
   logic [ROW_W-1:0]         s2_row_in;
   logic [PATTERN_BYTES-1:0] s2_mask_in;
   logic                     s2_en_in;
   logic                     s2_vld_ff;
   logic [RIW-1:0]           s2_idx_ff;
   logic                     s2_en_ff;
   logic [PATTERN_BYTES-1:0] s2_mask_ff;
   logic [ROW_W-1:0]         s2_row_ff;
   logic [PATTERN_BYTES-1:0] lane_ok;
   logic                     s2_match;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_verdict_ff, rsp_verdict_in;
   logic [15:0] rsp_class_ff, rsp_class_in;
   logic [15:0] final_class;

   // configuration writes
   always_comb begin
      floor_in      = floor_ff;
      rule_count_in = rule_count_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            cfmps_pkg::CSR_FLOOR:      floor_in      = csr_wr_data[0];
            cfmps_pkg::CSR_RULE_COUNT: rule_count_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   // number of rules scanned, capped at the table size
   assign rc_ext = {1'b0, rule_count_ff};
   assign active = (rc_ext > 7'(RULE_SLOTS)) ? AW'(RULE_SLOTS) : AW'(rc_ext);

   // pointer control
   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.ptr_clear) begin
         ptr_in = '0;
      end else if (cmd.ptr_step) begin
         ptr_in = ptr_ff + RIW'(1);
      end
   end

   // table writes from accepted header and pattern transfers
   assign wr_idx     = RIW'(req_item.rule_index);
   assign hdr_wr_en  = cmd.accept && (req_action == cfmps_pkg::ACTION_HDR) &&
                       (7'(req_item.rule_index) < 7'(RULE_SLOTS));
   assign pat_folded = cfmps_pkg::fold_byte(req_item.data_byte);

   always_comb begin
      for (int j = 0; j < PATTERN_BYTES; j++) begin
         lane_we[j] = cmd.accept && (req_action == cfmps_pkg::ACTION_PAT) &&
                      (7'(req_item.rule_index) < 7'(RULE_SLOTS)) &&
                      ({1'b0, req_item.byte_pos} == 7'(j));
      end
   end

   cfmps_ram #(
      .WIDTH (HDR_W),
      .DEPTH (RULE_SLOTS)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (hdr_wr_en),
      .wr_addr (wr_idx),
      .wr_data ({req_item.rule_class, req_item.pattern_length}),
      .rd_addr (ptr_ff),
      .rd_data (hdr_q)
   );

   for (genvar g = 0; g < PATTERN_BYTES; g++) begin : g_lane
      cfmps_ram #(
         .WIDTH (8),
         .DEPTH (RULE_SLOTS)
      ) u_lane_ram (
         .clock   (clock),
         .wr_en   (lane_we[g]),
         .wr_addr (wr_idx),
         .wr_data (pat_folded),
         .rd_addr (ptr_ff),
         .rd_data (lane_q[g])
      );
   end

   // text intake and query bookkeeping
   assign take_text   = cmd.accept && (req_action == cfmps_pkg::ACTION_TEXT);
   assign switch_text = take_text && req_second && !in_second_ff;

   always_comb begin
      bytes_seen_in  = bytes_seen_ff;
      item_last_in   = item_last_ff;
      in_second_in   = in_second_ff;
      first_class_in = first_class_ff;
      if (cmd.accept) begin
         item_last_in = (req_action == cfmps_pkg::ACTION_END) ||
                        ((req_action == cfmps_pkg::ACTION_TEXT) && req_last);
      end
      if (switch_text) begin
         bytes_seen_in = BSW'(1);
      end else if (take_text && (bytes_seen_ff != BSW'(PATTERN_BYTES))) begin
         bytes_seen_in = bytes_seen_ff + BSW'(1);
      end
      if (cmd.first_commit) begin
         first_class_in = cur_class_ff;
         in_second_in   = 1'b1;
      end
      if (cmd.query_clear) begin
         bytes_seen_in  = '0;
         in_second_in   = 1'b0;
         first_class_in = '0;
      end
   end

   // class of the lowest hit rule
   always_comb begin
      cur_class_in = cur_class_ff;
      if (cmd.class_capture) begin
         cur_class_in = hdr_vld_q_ff ? hdr_q[HDR_W-1:7] : 16'd0;
      end else if (cmd.class_zero) begin
         cur_class_in = '0;
      end
   end

   // stage 2: align the reversed pattern row to the window, build lane mask
   assign s1_len = hdr_vld_q_ff ? hdr_q[6:0] : 7'd0;
   assign shamt  = SHW'(8'(PATTERN_BYTES) - {1'b0, s1_len});

   always_comb begin
      for (int m = 0; m < PATTERN_BYTES; m++) begin
         rev_row[8*m +: 8] = lane_q[PATTERN_BYTES-1-m];
      end
      s2_row_in = rev_row >> {shamt, 3'b000};
      for (int k = 0; k < PATTERN_BYTES; k++) begin
         s2_mask_in[k] = 8'(k) < {1'b0, s1_len};
      end
      s2_en_in = (s1_len != 7'd0) && ({1'b0, s1_len} <= 8'(PATTERN_BYTES)) &&
                 ({1'b0, s1_len} <= 8'(bytes_seen_ff));
   end

   // stage 3: compare masked lanes with the folded window
   always_comb begin
      for (int k = 0; k < PATTERN_BYTES; k++) begin
         lane_ok[k] = !s2_mask_ff[k] || (s2_row_ff[8*k +: 8] == window_ff[k]);
      end
      s2_match = &lane_ok;
   end

   // result formation and output register
   assign final_class = (in_second_ff && (first_class_ff != 16'd0)) ?
                        first_class_ff : cur_class_ff;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_class_in   = rsp_class_ff;
      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
         if (!floor_ff) begin
            rsp_verdict_in = cfmps_pkg::VERDICT_FAILSAFE;
            rsp_class_in   = '0;
         end else if (final_class != 16'd0) begin
            rsp_verdict_in = cfmps_pkg::VERDICT_REFUSE;
            rsp_class_in   = final_class;
         end else begin
            rsp_verdict_in = cfmps_pkg::VERDICT_ALLOW;
            rsp_class_in   = '0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff       <= 1'b0;
         rule_count_ff  <= '0;
         ptr_ff         <= '0;
         hdr_valid_ff   <= '0;
         bytes_seen_ff  <= '0;
         item_last_ff   <= 1'b0;
         in_second_ff   <= 1'b0;
         first_class_ff <= '0;
         hit_flags_ff   <= '0;
         s1_vld_ff      <= 1'b0;
         s2_vld_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         floor_ff       <= floor_in;
         rule_count_ff  <= rule_count_in;
         ptr_ff         <= ptr_in;
         bytes_seen_ff  <= bytes_seen_in;
         item_last_ff   <= item_last_in;
         in_second_ff   <= in_second_in;
         first_class_ff <= first_class_in;
         s1_vld_ff      <= cmd.scan_issue;
         s2_vld_ff      <= s1_vld_ff;
         rsp_valid_ff   <= rsp_valid_in;
         if (hdr_wr_en) begin
            hdr_valid_ff[wr_idx] <= 1'b1;
         end
         if (cmd.query_clear || cmd.first_commit) begin
            hit_flags_ff <= '0;
         end else if (s2_vld_ff && s2_en_ff && s2_match) begin
            hit_flags_ff[s2_idx_ff] <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hdr_vld_q_ff   <= hdr_valid_ff[ptr_ff];
      cur_class_ff   <= cur_class_in;
      s1_idx_ff      <= ptr_ff;
      s2_idx_ff      <= s1_idx_ff;
      s2_en_ff       <= s2_en_in;
      s2_mask_ff     <= s2_mask_in;
      s2_row_ff      <= s2_row_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_class_ff   <= rsp_class_in;
      if (take_text) begin
         window_ff[0] <= pat_folded;
         for (int k = 1; k < PATTERN_BYTES; k++) begin
            window_ff[k] <= window_ff[k-1];
         end
      end
   end

   // status back to the controller
   assign status.active_zero = (active == AW'(0));
   assign status.ptr_last    = (active == AW'(0)) || ((AW'(ptr_ff) + AW'(1)) == active);
   assign status.hit_at_ptr  = (active != AW'(0)) && hit_flags_ff[ptr_ff];
   assign status.pipe_busy   = s1_vld_ff || s2_vld_ff;
   assign status.item_last   = item_last_ff;
   assign status.in_second   = in_second_ff;
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;
   assign rsp_class   = rsp_class_ff;

endmodule

@@ src/cfmps_ctrl.sv @@
// scanner controller: sequences writes, rule scans, class searches and results
module cfmps_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [1:0]               req_action,
   input  logic                     req_second,
   input  logic                     req_last,
   input  cfmps_pkg::dp_status_type status,
   output cfmps_pkg::ctrl_cmd_type  cmd,
   output logic                     req_ready
);

   cfmps_pkg::state_type state_ff, state_in;
   logic                 switch_text;

   assign switch_text = req_second && !status.in_second;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cfmps_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req_action)
                  cfmps_pkg::ACTION_TEXT: begin
                     if (switch_text) begin
                        state_in = cfmps_pkg::ST_SEARCH_FIRST;
                     end else if (!status.active_zero) begin
                        state_in = cfmps_pkg::ST_SCAN;
                     end else if (req_last) begin
                        state_in = cfmps_pkg::ST_SEARCH_END;
                     end
                  end
                  cfmps_pkg::ACTION_END: state_in = cfmps_pkg::ST_SEARCH_END;
                  default: state_in = cfmps_pkg::ST_IDLE;
               endcase
            end
         end
         cfmps_pkg::ST_SEARCH_FIRST: begin
            priority if (status.hit_at_ptr) begin
               state_in = cfmps_pkg::ST_LOOKUP_FIRST;
            end else if (status.ptr_last) begin
               state_in = cfmps_pkg::ST_COMMIT_FIRST;
            end
         end
         cfmps_pkg::ST_LOOKUP_FIRST: state_in = cfmps_pkg::ST_COMMIT_FIRST;
         cfmps_pkg::ST_COMMIT_FIRST: begin
            priority if (!status.active_zero) begin
               state_in = cfmps_pkg::ST_SCAN;
            end else if (status.item_last) begin
               state_in = cfmps_pkg::ST_SEARCH_END;
            end else begin
               state_in = cfmps_pkg::ST_IDLE;
            end
         end
         cfmps_pkg::ST_SCAN: begin
            if (status.ptr_last) begin
               state_in = cfmps_pkg::ST_DRAIN;
            end
         end
         cfmps_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = status.item_last ? cfmps_pkg::ST_SEARCH_END : cfmps_pkg::ST_IDLE;
            end
         end
         cfmps_pkg::ST_SEARCH_END: begin
            priority if (status.hit_at_ptr) begin
               state_in = cfmps_pkg::ST_LOOKUP_END;
            end else if (status.ptr_last) begin
               state_in = cfmps_pkg::ST_RESULT;
            end
         end
         cfmps_pkg::ST_LOOKUP_END: state_in = cfmps_pkg::ST_RESULT;
         cfmps_pkg::ST_RESULT: begin
            if (status.out_free) begin
               state_in = cfmps_pkg::ST_IDLE;
            end
         end
         default: state_in = cfmps_pkg::ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         cfmps_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.accept    = req_valid;
            cmd.ptr_clear = 1'b1;
         end
         cfmps_pkg::ST_SEARCH_FIRST, cfmps_pkg::ST_SEARCH_END: begin
            priority if (status.hit_at_ptr) begin
               cmd.ptr_step = 1'b0;
            end else if (status.ptr_last) begin
               cmd.class_zero = 1'b1;
            end else begin
               cmd.ptr_step = 1'b1;
            end
         end
         cfmps_pkg::ST_LOOKUP_FIRST, cfmps_pkg::ST_LOOKUP_END: begin
            cmd.class_capture = 1'b1;
         end
         cfmps_pkg::ST_COMMIT_FIRST: begin
            cmd.first_commit = 1'b1;
            cmd.ptr_clear    = 1'b1;
         end
         cfmps_pkg::ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            cmd.ptr_step   = !status.ptr_last;
         end
         cfmps_pkg::ST_DRAIN: begin
            cmd.ptr_clear = 1'b1;
         end
         cfmps_pkg::ST_RESULT: begin
            cmd.result_load = status.out_free;
            cmd.query_clear = status.out_free;
         end
         default: ;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfmps_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/case_folded_multi_pattern_scanner.sv @@
// Case-folded multi-pattern scanner, top level. Rule headers and pattern bytes
// are loaded through the request stream, and a table write leaves the block
// ready for the next transfer. Every query text byte is checked against all
// active rules, one rule per cycle, through a three-stage pipeline: a read of
// all pattern lanes at the rule's address, align, and compare. The first byte
// of a second text adds a search for the lowest matching rule of the first
// text, and query end adds a search and a load of the result, which waits
// while an earlier result still waits on rsp_tready. The pattern table holds
// no reset value and needs no clearing pass; header and class entries read as
// zero until written. The result register lets the block take the next
// transfers while a result waits on rsp_tready.
module case_folded_multi_pattern_scanner #(
   parameter int RULE_SLOTS    = 32,
   parameter int PATTERN_BYTES = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: rule_index[4:0], byte_pos[10:5], data_byte[18:11],
   //        pattern_length[25:19], rule_class[41:26], zero fill[47:42]
   input  logic [cfmps_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // tuser: action[1:0], second_text[2]
   input  logic [cfmps_pkg::REQ_TUSER_W-1:0]  req_tuser,
   input  logic                               req_tlast,
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: verdict[1:0], matched_class[17:2], zero fill[23:18]
   output logic [cfmps_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // configuration write port
   input  logic                               csr_wr_en,
   input  logic [0:0]                         csr_index,
   input  logic [cfmps_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   cfmps_pkg::req_item_type  req_item;
   cfmps_pkg::ctrl_cmd_type  cmd;
   cfmps_pkg::dp_status_type status;
   logic [1:0]               rsp_verdict;
   logic [15:0]              rsp_class;

   // unpack request fields
   assign req_item.rule_index     = req_tdata[4:0];
   assign req_item.byte_pos       = req_tdata[10:5];
   assign req_item.data_byte      = req_tdata[18:11];
   assign req_item.pattern_length = req_tdata[25:19];
   assign req_item.rule_class     = req_tdata[41:26];

   cfmps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_action (req_tuser[1:0]),
      .req_second (req_tuser[2]),
      .req_last   (req_tlast),
      .status     (status),
      .cmd        (cmd),
      .req_ready  (req_tready)
   );

   cfmps_datapath #(
      .RULE_SLOTS    (RULE_SLOTS),
      .PATTERN_BYTES (PATTERN_BYTES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_action  (req_tuser[1:0]),
      .req_item    (req_item),
      .req_second  (req_tuser[2]),
      .req_last    (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_verdict (rsp_verdict),
      .rsp_class   (rsp_class)
   );

   // pack result fields
   assign rsp_tdata = {6'b000000, rsp_class, rsp_verdict};

endmodule

@@ src/cfmps_checker.sv @@
// port-level checker of the scanner, bound to the top level
`include "case_folded_multi_pattern_scanner_assert.svh"

module cfmps_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [cfmps_pkg::REQ_TUSER_W-1:0] req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [cfmps_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // a stalled result holds
   `CFMPS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // a refusal always carries a nonzero class
   `CFMPS_ASSERT_IMP(a_refuse_class, clock, reset, rsp_tvalid && (rsp_tdata[1:0] == cfmps_pkg::VERDICT_REFUSE), rsp_tdata[17:2] != 16'd0, "refusal with zero class")

   // allow and failsafe report no class
   `CFMPS_ASSERT_IMP(a_other_class, clock, reset, rsp_tvalid && (rsp_tdata[1:0] != cfmps_pkg::VERDICT_REFUSE), rsp_tdata[17:2] == 16'd0, "class on a non-refusal")

   // the block is ready again in the cycle after a table write
   `CFMPS_ASSERT_NXT(a_write_ready, clock, reset, req_tvalid && req_tready && ((req_tuser[1:0] == cfmps_pkg::ACTION_HDR) || (req_tuser[1:0] == cfmps_pkg::ACTION_PAT)), req_tready, "not ready after a table write")

endmodule

bind case_folded_multi_pattern_scanner cfmps_checker u_checker (.*);

@@ dv/tb_top.sv @@
// self-checking testbench for the case-folded multi-pattern scanner
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS         = 32;
   localparam int PAT_BYTES     = 64;
   localparam int SETTLE_CYCLES = 100;
   localparam int STALL_LIMIT   = 4000;
   localparam int MAX_GAP       = 40;

   // one request transfer, all fields unpacked
   typedef struct {
      logic [1:0]  action;
      logic [4:0]  rule;
      logic [5:0]  pos;
      logic [7:0]  data;
      logic [6:0]  plen;
      logic [15:0] cls;
      logic        second;
      logic        last;
   } scan_op_type;

   // one expected query verdict
   typedef struct {
      logic [1:0]  verdict;
      logic [15:0] cls;
   } verdict_type;

   logic                                clock;
   logic                                reset       = 1'b1;
   logic                                req_tvalid  = 1'b0;
   logic                                req_tready;
   logic [cfmps_pkg::REQ_TDATA_W-1:0]   req_tdata   = '0;
   logic [cfmps_pkg::REQ_TUSER_W-1:0]   req_tuser   = '0;
   logic                                req_tlast   = 1'b0;
   logic                                rsp_tvalid;
   logic                                rsp_tready  = 1'b0;
   logic [cfmps_pkg::RSP_TDATA_W-1:0]   rsp_tdata;
   logic                                csr_wr_en   = 1'b0;
   logic [0:0]                          csr_index   = '0;
   logic [cfmps_pkg::CSR_DATA_W-1:0]    csr_wr_data = '0;

   case_folded_multi_pattern_scanner dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // scanner shadow state
   logic [7:0]       pat_mem   [SLOTS][PAT_BYTES];
   bit               pat_valid [SLOTS][PAT_BYTES];
   logic [6:0]       len_mem   [SLOTS];
   logic [15:0]      cls_mem   [SLOTS];
   logic [7:0]       window    [PAT_BYTES];
   int               window_fill;
   logic [SLOTS-1:0] rule_hits;
   logic [15:0]      first_class;
   bit               second_open;
   bit               floor_ok;
   logic [5:0]       rule_limit;
   verdict_type      verdict_q[$];

   int mismatches = 0;
   int items_sent = 0;
   int idle_pct   = 0;
   int stall_pct  = 0;
   int hold_left  = 0;

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      if (c >= "A" && c <= "Z") return c + 8'd32;
      return c;
   endfunction

   function automatic int live_rules();
      return (rule_limit > SLOTS) ? SLOTS : int'(rule_limit);
   endfunction

   // class of the lowest matched rule below the current rule count
   function automatic logic [15:0] current_class();
      for (int i = 0; i < live_rules(); i++) begin
         if (rule_hits[i]) return cls_mem[i];
      end
      return '0;
   endfunction

   function automatic void clear_text();
      foreach (window[k]) window[k] = '0;
      window_fill = 0;
      rule_hits   = '0;
   endfunction

   function automatic void reset_model();
      foreach (pat_mem[i, j]) begin
         pat_mem[i][j]   = '0;
         pat_valid[i][j] = 1'b0;
      end
      foreach (len_mem[i]) begin
         len_mem[i] = '0;
         cls_mem[i] = '0;
      end
      clear_text();
      first_class = '0;
      second_open = 1'b0;
      floor_ok    = 1'b0;
      rule_limit  = '0;
   endfunction

   // shift one folded byte in and mark every rule whose pattern ends here
   function automatic void scan_text_byte(input logic [7:0] b);
      int len;
      bit same;
      for (int k = PAT_BYTES - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = to_lower(b);
      if (window_fill < PAT_BYTES) window_fill++;
      for (int i = 0; i < live_rules(); i++) begin
         len = int'(len_mem[i]);
         if (len == 0 || len > PAT_BYTES || len > window_fill) continue;
         same = 1'b1;
         for (int j = 0; j < len; j++) begin
            if (to_lower(pat_mem[i][j]) != window[len-1-j]) same = 1'b0;
         end
         if (same) rule_hits[i] = 1'b1;
      end
   endfunction

   // query end: pick the class, form the verdict, clear the query
   function automatic void close_query();
      logic [15:0] now_cls;
      logic [15:0] final_cls;
      verdict_type v;
      now_cls   = current_class();
      final_cls = (second_open && first_class != 0) ? first_class : now_cls;
      if (!floor_ok) begin
         v.verdict = cfmps_pkg::VERDICT_FAILSAFE;
         v.cls     = '0;
      end else if (final_cls != 0) begin
         v.verdict = cfmps_pkg::VERDICT_REFUSE;
         v.cls     = final_cls;
      end else begin
         v.verdict = cfmps_pkg::VERDICT_ALLOW;
         v.cls     = '0;
      end
      verdict_q.push_back(v);
      clear_text();
      first_class = '0;
      second_open = 1'b0;
   endfunction

   function automatic void apply_item(input scan_op_type op);
      case (op.action)
         cfmps_pkg::ACTION_HDR: begin
            len_mem[op.rule] = op.plen;
            cls_mem[op.rule] = op.cls;
         end
         cfmps_pkg::ACTION_PAT: begin
            pat_mem[op.rule][op.pos]   = op.data;
            pat_valid[op.rule][op.pos] = 1'b1;
         end
         cfmps_pkg::ACTION_TEXT: begin
            if (op.second && !second_open) begin
               first_class = current_class();
               second_open = 1'b1;
               clear_text();
            end
            scan_text_byte(op.data);
            if (op.last) close_query();
         end
         cfmps_pkg::ACTION_END: close_query();
      endcase
   endfunction

   // number of leading pattern positions of a rule that hold written bytes
   function automatic int written_prefix(input int rule);
      int n;
      n = 0;
      while (n < PAT_BYTES && pat_valid[rule][n]) n++;
      return n;
   endfunction

   // item builders, fields the action ignores get random values
   function automatic scan_op_type op_noise(input logic [1:0] action);
      scan_op_type op;
      op.action = action;
      op.rule   = 5'($urandom);
      op.pos    = 6'($urandom);
      op.data   = 8'($urandom);
      op.plen   = 7'($urandom);
      op.cls    = 16'($urandom);
      op.second = 1'($urandom);
      op.last   = 1'($urandom);
      return op;
   endfunction

   function automatic scan_op_type op_hdr(input int rule, input int len,
                                          input logic [15:0] cls);
      scan_op_type op;
      op      = op_noise(cfmps_pkg::ACTION_HDR);
      op.rule = 5'(rule);
      op.plen = 7'(len);
      op.cls  = cls;
      return op;
   endfunction

   function automatic scan_op_type op_pat(input int rule, input int pos, input logic [7:0] b);
      scan_op_type op;
      op      = op_noise(cfmps_pkg::ACTION_PAT);
      op.rule = 5'(rule);
      op.pos  = 6'(pos);
      op.data = b;
      return op;
   endfunction

   function automatic scan_op_type op_text(input logic [7:0] b, input bit second,
                                           input bit last);
      scan_op_type op;
      op        = op_noise(cfmps_pkg::ACTION_TEXT);
      op.data   = b;
      op.second = second;
      op.last   = last;
      return op;
   endfunction

   // mostly bytes near the folding range so that rules hit often
   function automatic logic [7:0] pick_byte();
      string letters;
      letters = "aAbBzZ@[`{";
      if ($urandom_range(0, 99) < 85) return letters[$urandom_range(0, letters.len() - 1)];
      return 8'($urandom);
   endfunction

   function automatic logic [15:0] random_class();
      if ($urandom_range(0, 99) < 15) return '0;
      return 16'($urandom);
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // present one request and hold it until the transfer
   task automatic send_item(input scan_op_type op);
      cfmps_pkg::req_item_type body;
      int                      gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      body.rule_index     = op.rule;
      body.byte_pos       = op.pos;
      body.data_byte      = op.data;
      body.pattern_length = op.plen;
      body.rule_class     = op.cls;
      req_tvalid <= 1'b1;
      req_tdata  <= {{(cfmps_pkg::REQ_TDATA_W - $bits(cfmps_pkg::req_item_type)){1'b0}},
                     body};
      req_tuser  <= {op.second, op.action};
      req_tlast  <= op.last;
      do @(posedge clock); while (!req_tready);
      apply_item(op);
      items_sent++;
   endtask

   task automatic send_text(input string s, input bit second, input bit closes);
      for (int i = 0; i < s.len(); i++) begin
         send_item(op_text(s[i], second, closes && i == s.len() - 1));
      end
   endtask

   // pattern bytes go first so a header never points at unwritten bytes
   task automatic load_rule(input int rule, input string pat, input logic [15:0] cls);
      for (int j = 0; j < pat.len(); j++) send_item(op_pat(rule, j, pat[j]));
      send_item(op_hdr(rule, pat.len(), cls));
   endtask

   task automatic wait_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (verdict_q.size() != 0);
   endtask

   task automatic wait_idle();
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_regs(input bit floor_bit, input logic [5:0] count);
      logic [4:0] filler;
      wait_idle();
      filler = 5'($urandom);
      csr_wr_en   <= 1'b1;
      csr_index   <= cfmps_pkg::CSR_FLOOR;
      csr_wr_data <= {filler, floor_bit};
      @(posedge clock);
      csr_index   <= cfmps_pkg::CSR_RULE_COUNT;
      csr_wr_data <= count;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      floor_ok   = floor_bit;
      rule_limit = count;
   endtask

   task automatic load_random_rule();
      int rule;
      int len;
      rule = $urandom_range(0, SLOTS - 1);
      if ($urandom_range(0, 19) == 0) len = $urandom_range(20, PAT_BYTES);
      else len = $urandom_range(1, 3);
      for (int j = 0; j < len; j++) send_item(op_pat(rule, j, pick_byte()));
      send_item(op_hdr(rule, len, random_class()));
   endtask

   // stray rule table writes: any byte anywhere, or a header that stays safe
   task automatic send_table_noise();
      int rule;
      int len;
      rule = $urandom_range(0, SLOTS - 1);
      if ($urandom_range(0, 1) == 1) begin
         send_item(op_pat(rule, $urandom_range(0, PAT_BYTES - 1), 8'($urandom)));
      end else begin
         case ($urandom_range(0, 2))
            0: len = 0;
            1: len = $urandom_range(PAT_BYTES + 1, 127);
            default: len = $urandom_range(0, written_prefix(rule));
         endcase
         send_item(op_hdr(rule, len, random_class()));
      end
   endtask

   task automatic send_random_query();
      int n1;
      int n2;
      bit by_end;
      n1 = $urandom_range(0, 10);
      n2 = ($urandom_range(0, 99) < 40) ? $urandom_range(1, 8) : 0;
      by_end = ($urandom_range(0, 99) < 25) || (n1 + n2 == 0);
      for (int i = 0; i < n1; i++) begin
         send_item(op_text(pick_byte(), 1'b0, !by_end && n2 == 0 && i == n1 - 1));
      end
      // a cleared second_text after the second text began stays in it
      for (int i = 0; i < n2; i++) begin
         send_item(op_text(pick_byte(), (i == 0) || ($urandom_range(0, 3) != 0),
                           !by_end && i == n2 - 1));
      end
      if (by_end) send_item(op_noise(cfmps_pkg::ACTION_END));
   endtask

   task automatic run_traffic(input int n_items);
      int stop_at;
      int pick;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) load_random_rule();
         else if (pick < 32) send_table_noise();
         else send_random_query();
      end
   endtask

   // registers still at reset: floor unverified, no rules
   task automatic test_reset_state();
      send_item(op_noise(cfmps_pkg::ACTION_END));
      send_text("a", 1'b0, 1'b1);
   endtask

   // folding on both sides, class-zero priority, zero length, short text
   task automatic test_folding();
      set_regs(1'b1, 6'd4);
      load_rule(0, "Ab", 16'hFFFF);
      load_rule(1, "[", 16'h0000);
      load_rule(2, "@", 16'h8001);
      send_item(op_hdr(3, 0, 16'h1111));
      send_text("aB", 1'b0, 1'b1);
      send_text("@", 1'b0, 1'b1);
      send_text("[@", 1'b0, 1'b1);
      send_text("b", 1'b0, 1'b1);
   endtask

   task automatic test_second_text();
      send_text("x", 1'b0, 1'b0);
      send_text("@", 1'b1, 1'b1);
      send_text("Ab", 1'b0, 1'b0);
      send_text("@", 1'b1, 1'b1);
      // empty first text, then a byte that tries to go back to the first text
      send_item(op_text("[", 1'b1, 1'b0));
      send_item(op_text("@", 1'b0, 1'b1));
   endtask

   // rule counts at zero, just above the table and at the top of the register
   task automatic test_rule_limits();
      set_regs(1'b1, 6'd0);
      send_text("@", 1'b0, 1'b1);
      set_regs(1'b1, 6'd63);
      send_item(op_hdr(3, 127, 16'h4321));
      send_text("@Ab", 1'b0, 1'b1);
      set_regs(1'b1, 6'd33);
      send_text("ab", 1'b0, 1'b1);
   endtask

   task automatic test_failsafe();
      set_regs(1'b0, 6'd32);
      run_traffic(60);
   endtask

   task automatic test_random_traffic();
      idle_pct  = 0;
      stall_pct = 0;
      set_regs(1'b1, 6'd32);
      run_traffic(350);
      idle_pct = 74;
      set_regs(1'b1, 6'd20);
      run_traffic(250);
      idle_pct  = 0;
      stall_pct = 74;
      set_regs(1'b1, 6'd63);
      run_traffic(250);
      idle_pct  = 25;
      stall_pct = 25;
      set_regs(1'b1, 6'd33);
      run_traffic(250);
   endtask

   // results held back long enough that the block stops taking requests
   task automatic test_result_backpressure();
      idle_pct  = 0;
      stall_pct = 0;
      set_regs(1'b1, 6'd32);
      hold_left = 600;
      repeat (30) send_item(op_text(pick_byte(), 1'b0, 1'b1));
   endtask

   task automatic test_drain_pause();
      repeat (5) send_random_query();
      wait_results();
      repeat (5) send_random_query();
   endtask

   // result receiver: random stalls plus an optional long hold-off
   initial begin : result_sink
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // compare every result transfer with the oldest expected verdict
   always @(posedge clock) begin : check_results
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_q.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata[17:2], '0);
         end else begin
            want = verdict_q.pop_front();
            if (rsp_tdata[1:0] !== want.verdict)
               report_mismatch("verdict", 16'(rsp_tdata[1:0]), 16'(want.verdict));
            if (rsp_tdata[17:2] !== want.cls)
               report_mismatch("matched_class", rsp_tdata[17:2], want.cls);
         end
      end
   end

   // no transfer for too long ends the run
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en || reset)
            quiet = 0;
         else
            quiet++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      reset_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_folding();
      test_second_text();
      test_rule_limits();
      test_failsafe();
      test_random_traffic();
      test_result_backpressure();
      test_drain_pause();
      wait_idle();
      if (mismatches == 0 && verdict_q.size() == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
